@@ hdl/wkt_sv_pkg.sv @@
// Shared token and grammar-state definitions for the WKT syntax validator.
`default_nettype none

package wkt_sv_pkg;

	// Token classes seen by the grammar checker (also the previous-token record)
	localparam logic [2:0] PK_NONE   = 3'd0;
	localparam logic [2:0] PK_KEY    = 3'd1;
	localparam logic [2:0] PK_EMPTY  = 3'd2;
	localparam logic [2:0] PK_NUMBER = 3'd3;
	localparam logic [2:0] PK_LB     = 3'd4;
	localparam logic [2:0] PK_RB     = 3'd5;
	localparam logic [2:0] PK_COMMA  = 3'd6;

	// Grammar state that travels between the tokenizer and the grammar checker
	typedef struct packed {
		logic       failed;
		logic [2:0] coord_cnt;
		logic [2:0] prev_kind;
	} gram_t;

endpackage : wkt_sv_pkg

`default_nettype wire

@@ hdl/wkt_sv_grammar.sv @@
// Grammar checker step: previous token, bracket depth and coordinate count.
`default_nettype none

module wkt_sv_grammar #(
	parameter int MAX_NESTING = 255,
	parameter int DEPTH_W     = 8
) (
	input  wire                 fire,
	input  wire [2:0]           tok,
	input  wkt_sv_pkg::gram_t   st_in,
	input  wire [DEPTH_W-1:0]   depth_in,
	output wkt_sv_pkg::gram_t   st_out,
	output logic [DEPTH_W-1:0]  depth_out
);
	import wkt_sv_pkg::*;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_NESTING);

	logic fail;
	logic open_fail;
	logic close_fail;
	logic count_ok;

	assign open_fail  = (depth_in >= DEPTH_MAX);
	assign close_fail = (depth_in == '0);
	assign count_ok   = st_in.coord_cnt inside {3'd2, 3'd3};

	always_comb begin
		st_out    = st_in;
		depth_out = depth_in;
		fail      = 1'b0;
		if (fire && !st_in.failed) begin
			case (st_in.prev_kind)
				PK_NONE: begin
					fail = (tok != PK_KEY);
				end
				PK_KEY: begin
					if (tok == PK_LB) begin
						fail = open_fail;
						if (!open_fail) depth_out = depth_in + DEPTH_W'(1);
					end else begin
						fail = !(tok == PK_KEY || tok == PK_EMPTY);
					end
				end
				PK_LB: begin
					if (tok == PK_NUMBER) begin
						st_out.coord_cnt = 3'd1;
					end else if (tok == PK_LB) begin
						fail = open_fail;
						if (!open_fail) depth_out = depth_in + DEPTH_W'(1);
					end else begin
						fail = (tok != PK_KEY);
					end
				end
				PK_NUMBER: begin
					if (tok == PK_NUMBER) begin
						if (st_in.coord_cnt < 3'd4) st_out.coord_cnt = st_in.coord_cnt + 3'd1;
					end else if (tok == PK_COMMA) begin
						fail = !count_ok;
					end else if (tok == PK_RB) begin
						fail = close_fail || !count_ok;
						if (!close_fail) depth_out = depth_in - DEPTH_W'(1);
						st_out.coord_cnt = 3'd0;
					end else begin
						fail = 1'b1;
					end
				end
				PK_COMMA: begin
					if (tok == PK_NUMBER) begin
						st_out.coord_cnt = 3'd1;
					end else if (tok == PK_LB) begin
						fail = open_fail || (st_in.coord_cnt != 3'd0);
						if (!open_fail) depth_out = depth_in + DEPTH_W'(1);
					end else if (tok == PK_RB) begin
						fail = close_fail || (st_in.coord_cnt != 3'd0);
						if (!close_fail) depth_out = depth_in - DEPTH_W'(1);
					end else begin
						fail = (tok != PK_KEY);
					end
				end
				PK_RB: begin
					if (tok == PK_RB) begin
						fail = close_fail;
						if (!close_fail) depth_out = depth_in - DEPTH_W'(1);
					end else begin
						fail = !(tok == PK_COMMA || tok == PK_KEY);
					end
				end
				default: begin
					fail = 1'b1;
				end
			endcase
			st_out.failed = fail;
			if (!fail) st_out.prev_kind = tok;
		end
	end

endmodule : wkt_sv_grammar

`default_nettype wire

@@ hdl/wkt_syntax_validator.sv @@
// Top level of the WKT geometry syntax validator: tokenizer, grammar and stream stages.
//
// Usage: feed the characters of one geometry string as words on the s_axis
// channel, one byte per word in tdata. Close the string with a word that has
// tlast high; that word carries no character and its tdata is ignored. For
// every tlast word the block returns exactly one word on m_axis: bit 0 of
// tdata is 1 when the string is well-formed geometry text, 0 when rejected.
// Character words produce no output word.
// Path: a word is checked while it sits in the input register; the verdict
// is loaded into the output register when the end word moves on and is
// shown on m_axis from there. Throughput: one word per cycle while no end
// word waits behind a stalled verdict, set by the state update of tokenizer
// plus two chained grammar steps.
// Stall: a waiting verdict sits in the output register; character words keep
// flowing behind it, and only a second tlast word waits in the input register
// until the verdict is taken.
// Reset: arst_n clears the stages and the parse state; the next word starts
// a new string. After each verdict the parse state restarts on its own.
// Nesting deeper than MAX_NESTING brackets rejects the string.
`default_nettype none

module wkt_syntax_validator #(
	parameter int MAX_NESTING = 255
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire [7:0]  s_axis_tdata,   // [7:0] char_byte
	input  wire        s_axis_tlast,   // end_mark
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [7:0] m_axis_tdata    // [0] is_valid, [7:1] zero
);
	import wkt_sv_pkg::*;

	localparam int DEPTH_W = $clog2(MAX_NESTING + 1);

	// Tokenizer modes
	localparam logic [1:0] TK_IDLE = 2'd0;
	localparam logic [1:0] TK_KEY  = 2'd1;
	localparam logic [1:0] TK_NUM  = 2'd2;

	// Number scanner phases (DONE and ERROR are never stored)
	localparam logic [3:0] NP_SIGN    = 4'd0;
	localparam logic [3:0] NP_INT     = 4'd1;
	localparam logic [3:0] NP_DOT     = 4'd2;
	localparam logic [3:0] NP_FRAC    = 4'd3;
	localparam logic [3:0] NP_EXP     = 4'd4;
	localparam logic [3:0] NP_EXPSIGN = 4'd5;
	localparam logic [3:0] NP_EXPNUM  = 4'd6;
	localparam logic [3:0] NP_DONE    = 4'd7;
	localparam logic [3:0] NP_ERROR   = 4'd8;

	// Character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_LO_E  = 8'h65;
	localparam logic [7:0] CH_UP_E  = 8'h45;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_num_end(input logic [7:0] c);
		return is_blank(c) || (c == CH_COMMA) || (c == CH_RPAR);
	endfunction

	function automatic logic is_exp(input logic [7:0] c);
		return (c == CH_LO_E) || (c == CH_UP_E);
	endfunction

	// Lower-case letters of the EMPTY keyword by position
	function automatic logic [7:0] empty_letter(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0:    ch = 8'h65;
			3'd1:    ch = 8'h6D;
			3'd2:    ch = 8'h70;
			3'd3:    ch = 8'h74;
			3'd4:    ch = 8'h79;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [3:0] number_next(input logic [2:0] phase, input logic [7:0] c);
		logic [3:0] r;
		case ({1'b0, phase})
			NP_INT: begin
				if (is_exp(c))          r = NP_EXP;
				else if (is_num_end(c)) r = NP_DONE;
				else if (is_digit(c))   r = NP_INT;
				else if (c == CH_DOT)   r = NP_DOT;
				else                    r = NP_ERROR;
			end
			NP_SIGN: begin
				if (is_digit(c))        r = NP_INT;
				else if (c == CH_DOT)   r = NP_DOT;
				else                    r = NP_ERROR;
			end
			NP_DOT, NP_FRAC: begin
				if (is_digit(c))        r = NP_FRAC;
				else if (is_exp(c))     r = NP_EXP;
				else if (is_num_end(c)) r = NP_DONE;
				else                    r = NP_ERROR;
			end
			NP_EXP: begin
				if (c == CH_PLUS || c == CH_MINUS) r = NP_EXPSIGN;
				else if (is_digit(c))              r = NP_EXPNUM;
				else                               r = NP_ERROR;
			end
			NP_EXPSIGN: begin
				r = is_digit(c) ? NP_EXPNUM : NP_ERROR;
			end
			NP_EXPNUM: begin
				if (is_digit(c))        r = NP_EXPNUM;
				else if (is_num_end(c)) r = NP_DONE;
				else                    r = NP_ERROR;
			end
			default: r = NP_ERROR;
		endcase
		return r;
	endfunction

	// Input register stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// Output register
	logic       out_valid_q;
	logic       out_data_q;

	// Parse state
	logic [1:0]         tk_q;
	logic [2:0]         np_q;
	logic [2:0]         kl_q;
	logic               km_q;
	gram_t              gram_q;
	logic [DEPTH_W-1:0] depth_q;

	// Next-state logic
	logic [1:0]         tk_n;
	logic [2:0]         np_n;
	logic [2:0]         kl_n;
	logic               km_n;
	logic               tok_fail;
	logic               scan_fail;
	logic               scan_req;
	logic               scan_run;
	logic               g1_fire;
	logic [2:0]         g1_tok;
	logic               g2_fire;
	logic [2:0]         g2_tok;
	gram_t              g1_st;
	gram_t              g2_st;
	gram_t              gram_n;
	logic [DEPTH_W-1:0] g1_depth;
	logic [DEPTH_W-1:0] g2_depth;
	logic [3:0]         np_r;
	logic               verdict;
	logic               advance;
	logic               out_free;

	// Handshake: a character word always moves on; an end word moves on when
	// the output register is free or is being emptied this cycle.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_data_q};

	// First grammar step: a keyword or number closed by this byte (or the end word)
	wkt_sv_grammar #(
		.MAX_NESTING (MAX_NESTING),
		.DEPTH_W     (DEPTH_W)
	) u_gram1 (
		.fire      (g1_fire),
		.tok       (g1_tok),
		.st_in     (gram_q),
		.depth_in  (depth_q),
		.st_out    (g1_st),
		.depth_out (g1_depth)
	);

	// Second grammar step: a bracket or comma scanned from the same byte
	wkt_sv_grammar #(
		.MAX_NESTING (MAX_NESTING),
		.DEPTH_W     (DEPTH_W)
	) u_gram2 (
		.fire      (g2_fire),
		.tok       (g2_tok),
		.st_in     (g1_st),
		.depth_in  (g1_depth),
		.st_out    (g2_st),
		.depth_out (g2_depth)
	);

	assign scan_run = scan_req && !g1_st.failed;
	assign verdict  = !g1_st.failed && (g1_depth == '0) &&
		(g1_st.prev_kind == PK_RB || g1_st.prev_kind == PK_EMPTY);

	// Fold tokenizer and scan errors into the grammar state
	always_comb begin
		gram_n        = g2_st;
		gram_n.failed = g2_st.failed || tok_fail || scan_fail;
	end

	// Tokenizer: close the open token first, then rescan the byte from idle.
	always_comb begin
		tk_n      = tk_q;
		np_n      = np_q;
		kl_n      = kl_q;
		km_n      = km_q;
		tok_fail  = 1'b0;
		scan_req  = 1'b0;
		g1_fire   = 1'b0;
		g1_tok    = PK_KEY;
		np_r      = number_next(np_q, last_s1 ? CH_SPACE : char_s1);
		if (!gram_q.failed) begin
			if (tk_q == TK_KEY) begin
				if (last_s1 || is_blank(char_s1) || char_s1 == CH_LPAR) begin
					g1_fire  = 1'b1;
					g1_tok   = (kl_q == 3'd5 && km_q) ? PK_EMPTY : PK_KEY;
					tk_n     = TK_IDLE;
					scan_req = !last_s1;
				end else if (is_letter(char_s1)) begin
					if (kl_q < 3'd5 && char_s1 != empty_letter(kl_q) &&
							char_s1 != (empty_letter(kl_q) & 8'hDF)) begin
						km_n = 1'b0;
					end
					if (kl_q < 3'd6) kl_n = kl_q + 3'd1;
				end else begin
					tok_fail = 1'b1;
					tk_n     = TK_IDLE;
				end
			end else if (tk_q == TK_NUM) begin
				if (np_r == NP_DONE) begin
					g1_fire  = 1'b1;
					g1_tok   = PK_NUMBER;
					tk_n     = TK_IDLE;
					scan_req = !last_s1;
				end else if (last_s1) begin
					// drop an unfinished trailing number
					tk_n = TK_IDLE;
				end else if (np_r == NP_ERROR) begin
					tok_fail = 1'b1;
					tk_n     = TK_IDLE;
				end else begin
					np_n = np_r[2:0];
				end
			end else begin
				scan_req = !last_s1;
			end
		end
	end

	// Idle scan of the current byte
	always_comb begin
		g2_fire   = 1'b0;
		g2_tok    = PK_COMMA;
		scan_fail = 1'b0;
		if (scan_run) begin
			if (is_blank(char_s1)) begin
				g2_fire = 1'b0;
			end else if (is_letter(char_s1)) begin
				g2_fire = 1'b0;
			end else if (is_digit(char_s1) || char_s1 == CH_DOT ||
					char_s1 == CH_PLUS || char_s1 == CH_MINUS) begin
				g2_fire = 1'b0;
			end else if (char_s1 == CH_LPAR) begin
				g2_fire = 1'b1;
				g2_tok  = PK_LB;
			end else if (char_s1 == CH_RPAR) begin
				g2_fire = 1'b1;
				g2_tok  = PK_RB;
			end else if (char_s1 == CH_COMMA) begin
				g2_fire = 1'b1;
				g2_tok  = PK_COMMA;
			end else begin
				scan_fail = 1'b1;
			end
		end
	end

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Output register: load the verdict, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q  <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
			out_data_q  <= verdict;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Parse state: advance per character word, restart after each end word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tk_q    <= TK_IDLE;
			np_q    <= 3'd0;
			kl_q    <= 3'd0;
			km_q    <= 1'b1;
			gram_q  <= '{failed: 1'b0, coord_cnt: 3'd0, prev_kind: PK_NONE};
			depth_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				tk_q    <= TK_IDLE;
				np_q    <= 3'd0;
				kl_q    <= 3'd0;
				km_q    <= 1'b1;
				gram_q  <= '{failed: 1'b0, coord_cnt: 3'd0, prev_kind: PK_NONE};
				depth_q <= '0;
			end else begin
				gram_q  <= gram_n;
				depth_q <= g2_depth;
				if (scan_run && is_letter(char_s1)) begin
					// start a keyword with its first letter
					tk_q <= TK_KEY;
					kl_q <= 3'd1;
					km_q <= (char_s1 == CH_LO_E) || (char_s1 == CH_UP_E);
					np_q <= np_n;
				end else if (scan_run && (is_digit(char_s1) || char_s1 == CH_DOT ||
						char_s1 == CH_PLUS || char_s1 == CH_MINUS)) begin
					tk_q <= TK_NUM;
					kl_q <= kl_n;
					km_q <= km_n;
					if (is_digit(char_s1))     np_q <= NP_INT[2:0];
					else if (char_s1 == CH_DOT) np_q <= NP_DOT[2:0];
					else                        np_q <= NP_SIGN[2:0];
				end else begin
					tk_q <= tk_n;
					np_q <= np_n;
					kl_q <= kl_n;
					km_q <= km_n;
				end
			end
		end
	end

endmodule : wkt_syntax_validator

`default_nettype wire

@@ hdl/wkt_sv_checker.sv @@
// Port-level checker for the WKT syntax validator and its bind statement.
`default_nettype none

module wkt_sv_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       s_axis_tvalid,
	input wire       s_axis_tready,
	input wire       s_axis_tlast,
	input wire       m_axis_tvalid,
	input wire       m_axis_tready,
	input wire [7:0] m_axis_tdata
);
	// End words taken whose verdict has not yet been taken
	logic [1:0] pending_q;
	logic       end_in;
	logic       res_out;

	assign end_in  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
	assign res_out = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else begin
			pending_q <= pending_q + {1'b0, end_in} - {1'b0, res_out};
		end
	end

	// Hold a stalled verdict
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("verdict dropped or changed while stalled");

	// No verdict without an end word still owed one
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pending_q != 2'd0)
		else $error("verdict without pending end word");

	// At most one end word waits behind a stalled verdict
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 2'd2)
		else $error("more end words in flight than stages");

	// Input is stalled only when both stages hold end words
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q < 2'd2 |-> s_axis_tready)
		else $error("input stalled without a full pipeline");

	// Upper verdict bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
		else $error("nonzero padding in verdict word");

endmodule : wkt_sv_checker

bind wkt_syntax_validator wkt_sv_checker u_wkt_sv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ sim/wkt_verdict_checker.sv @@
// Verdict predictor and scoreboard for the WKT syntax validator streams.
module wkt_verdict_checker #(
	parameter int MAX_NESTING = 255
) (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       s_axis_tvalid,
	input  wire       s_axis_tready,
	input  wire [7:0] s_axis_tdata,   // [7:0] char_byte
	input  wire       s_axis_tlast,   // end_mark
	input  wire       m_axis_tvalid,
	input  wire       m_axis_tready,
	input  wire [7:0] m_axis_tdata,   // [0] is_valid, [7:1] zero
	output int        fail_count,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import wkt_sv_pkg::*;

	typedef enum logic [1:0] {SCAN_BLANK, SCAN_WORD, SCAN_NUMBER} scan_t;
	typedef enum logic [3:0] {
		NUM_SIGN, NUM_INT, NUM_POINT, NUM_FRAC, NUM_EXP,
		NUM_EXP_SIGN, NUM_EXP_DIGITS, NUM_DONE, NUM_BAD
	} num_phase_t;

	localparam logic [39:0] EMPTY_TEXT = "EMPTY";

	scan_t       scan = SCAN_BLANK;
	num_phase_t  num_phase = NUM_SIGN;
	logic [2:0]  word_len = '0;
	logic        word_is_empty = 1'b1;
	logic [2:0]  last_kind = PK_NONE;
	int unsigned depth = 0;
	logic [2:0]  coord_n = '0;
	logic        rejected = 1'b0;

	logic [7:0]  verdicts [$];
	logic [7:0]  want;
	int          fails = 0;
	int          waiting = 0;

	assign fail_count = fails;
	assign pending    = waiting;

	function automatic logic is_blank(logic [7:0] c);
		return c == " " || c == 8'h09;
	endfunction

	function automatic logic is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic ends_number(logic [7:0] c);
		return is_blank(c) || c == "," || c == ")";
	endfunction

	function automatic logic is_exp_mark(logic [7:0] c);
		return c == "e" || c == "E";
	endfunction

	function automatic num_phase_t next_phase(num_phase_t ph, logic [7:0] c);
		case (ph)
		NUM_INT: begin
			if (is_exp_mark(c)) return NUM_EXP;
			if (ends_number(c)) return NUM_DONE;
			if (is_digit(c)) return NUM_INT;
			if (c == ".") return NUM_POINT;
			return NUM_BAD;
		end
		NUM_SIGN: begin
			if (is_digit(c)) return NUM_INT;
			if (c == ".") return NUM_POINT;
			return NUM_BAD;
		end
		NUM_POINT, NUM_FRAC: begin
			if (is_digit(c)) return NUM_FRAC;
			if (is_exp_mark(c)) return NUM_EXP;
			if (ends_number(c)) return NUM_DONE;
			return NUM_BAD;
		end
		NUM_EXP: begin
			if (c == "+" || c == "-") return NUM_EXP_SIGN;
			if (is_digit(c)) return NUM_EXP_DIGITS;
			return NUM_BAD;
		end
		NUM_EXP_SIGN: return is_digit(c) ? NUM_EXP_DIGITS : NUM_BAD;
		NUM_EXP_DIGITS: begin
			if (is_digit(c)) return NUM_EXP_DIGITS;
			if (ends_number(c)) return NUM_DONE;
			return NUM_BAD;
		end
		default: return NUM_BAD;
		endcase
	endfunction

	function void reset_parser();
		scan          = SCAN_BLANK;
		num_phase     = NUM_SIGN;
		word_len      = '0;
		word_is_empty = 1'b1;
		last_kind     = PK_NONE;
		depth         = 0;
		coord_n       = '0;
		rejected      = 1'b0;
	endfunction

	function void open_bracket();
		if (depth >= MAX_NESTING) rejected = 1'b1;
		else depth++;
	endfunction

	function void close_bracket();
		if (depth == 0) rejected = 1'b1;
		else depth--;
	endfunction

	function automatic logic coords_ok();
		return coord_n == 3'd2 || coord_n == 3'd3;
	endfunction

	// grammar step: accept or reject the next token given the one before it
	function void take_token(logic [2:0] t);
		if (rejected) return;
		case (last_kind)
		PK_NONE: if (t != PK_KEY) rejected = 1'b1;
		PK_KEY: begin
			if (t == PK_LB) open_bracket();
			else if (t != PK_KEY && t != PK_EMPTY) rejected = 1'b1;
		end
		PK_LB: begin
			if (t == PK_NUMBER) coord_n = 3'd1;
			else if (t == PK_LB) open_bracket();
			else if (t != PK_KEY) rejected = 1'b1;
		end
		PK_NUMBER: begin
			if (t == PK_NUMBER) begin
				if (coord_n < 3'd4) coord_n++;
			end else if (t == PK_COMMA) begin
				if (!coords_ok()) rejected = 1'b1;
			end else if (t == PK_RB) begin
				close_bracket();
				if (!coords_ok()) rejected = 1'b1;
				coord_n = '0;
			end else rejected = 1'b1;
		end
		PK_COMMA: begin
			if (t == PK_NUMBER) coord_n = 3'd1;
			else if (t == PK_LB) begin
				open_bracket();
				if (coord_n != 0) rejected = 1'b1;
			end else if (t == PK_RB) begin
				close_bracket();
				if (coord_n != 0) rejected = 1'b1;
			end else if (t != PK_KEY) rejected = 1'b1;
		end
		PK_RB: begin
			if (t == PK_RB) close_bracket();
			else if (t != PK_COMMA && t != PK_KEY) rejected = 1'b1;
		end
		default: rejected = 1'b1;
		endcase
		if (!rejected) last_kind = t;
	endfunction

	// track whether the keyword so far spells EMPTY in any letter case
	function void word_add(logic [7:0] c);
		logic [7:0] up;
		up = EMPTY_TEXT[8 * (4 - (word_len % 5)) +: 8];
		if (word_len < 3'd5 && c != up && c != (up | 8'h20)) word_is_empty = 1'b0;
		if (word_len < 3'd6) word_len++;
	endfunction

	function void word_close();
		scan = SCAN_BLANK;
		take_token((word_len == 3'd5 && word_is_empty) ? PK_EMPTY : PK_KEY);
	endfunction

	function void start_token(logic [7:0] c);
		if (is_blank(c)) return;
		if (is_letter(c)) begin
			scan          = SCAN_WORD;
			word_len      = '0;
			word_is_empty = 1'b1;
			word_add(c);
		end else if (is_digit(c)) begin
			scan      = SCAN_NUMBER;
			num_phase = NUM_INT;
		end else if (c == ".") begin
			scan      = SCAN_NUMBER;
			num_phase = NUM_POINT;
		end else if (c == "+" || c == "-") begin
			scan      = SCAN_NUMBER;
			num_phase = NUM_SIGN;
		end else if (c == "(") take_token(PK_LB);
		else if (c == ")") take_token(PK_RB);
		else if (c == ",") take_token(PK_COMMA);
		else rejected = 1'b1;
	endfunction

	// the byte that ends a keyword or number is scanned again as a new token
	function void consume(logic [7:0] c);
		num_phase_t nxt;
		if (rejected) return;
		if (scan == SCAN_WORD) begin
			if (is_blank(c) || c == "(") begin
				word_close();
				if (!rejected) start_token(c);
			end else if (is_letter(c)) word_add(c);
			else begin
				rejected = 1'b1;
				scan     = SCAN_BLANK;
			end
		end else if (scan == SCAN_NUMBER) begin
			nxt = next_phase(num_phase, c);
			if (nxt == NUM_DONE) begin
				scan = SCAN_BLANK;
				take_token(PK_NUMBER);
				if (!rejected) start_token(c);
			end else if (nxt == NUM_BAD) begin
				rejected = 1'b1;
				scan     = SCAN_BLANK;
			end else num_phase = nxt;
		end else start_token(c);
	endfunction

	// close an open token; an incomplete trailing number is simply dropped
	function automatic logic close_string();
		logic ok;
		if (!rejected) begin
			if (scan == SCAN_WORD) word_close();
			else if (scan == SCAN_NUMBER) begin
				if (next_phase(num_phase, " ") == NUM_DONE) take_token(PK_NUMBER);
				scan = SCAN_BLANK;
			end
		end
		ok = !rejected && depth == 0 && (last_kind == PK_RB || last_kind == PK_EMPTY);
		reset_parser();
		return ok;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_parser();
			verdicts.delete();
			waiting = 0;
		end else begin
			// compare before queuing: a verdict never leaves in the cycle its tlast enters
			if (m_axis_tvalid && m_axis_tready) begin
				if (verdicts.size() == 0) begin
					$display("%0t: verdict word %02h with none expected", $time, m_axis_tdata);
					fails++;
				end else begin
					want = verdicts.pop_front();
					if (m_axis_tdata !== want) begin
						$display("%0t: verdict mismatch, expected %02h got %02h",
							$time, want, m_axis_tdata);
						fails++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tlast) verdicts.push_back({7'd0, close_string()});
				else consume(s_axis_tdata);
			end
			waiting = verdicts.size();
		end
	end

endmodule : wkt_verdict_checker

@@ sim/wkt_syntax_validator_tb.sv @@
// Testbench top for the WKT syntax validator: clock, reset, string stimulus and verdict.
module wkt_syntax_validator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH_LIMIT = 255;
	localparam int CYCLE_LIMIT = 150000;
	localparam int IDLE_PCT    = 34;
	// receiver hold-off, in its own cycle count
	localparam int HOLD_START  = 300;
	localparam int HOLD_LEN    = 400;

	typedef logic [7:0] text_t [$];

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;   // [7:0] char_byte
	logic       s_axis_tlast;   // end_mark
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;   // [0] is_valid, [7:1] zero

	int         fail_count;
	int         pending;
	int unsigned cycle_count = 0;
	bit         steady_send = 1'b0;
	int         words_sent = 0;

	wkt_syntax_validator #(
		.MAX_NESTING(DEPTH_LIMIT)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	wkt_verdict_checker #(
		.MAX_NESTING(DEPTH_LIMIT)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// watchdog: a hung handshake ends the run here
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// receiver: random stalls, one long hold-off to back the block up,
	// no random stalls while the sender runs steady
	initial begin
		int rx_cycle;
		rx_cycle = 0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
				m_axis_tready <= 1'b0;
			else if (steady_send)
				m_axis_tready <= 1'b1;
			else
				m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// offer one word at a falling edge, hold it until taken, return at a falling edge
	task automatic send_word(input logic [7:0] ch, input logic last);
		while (!steady_send && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'($urandom_range(255));
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ch;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	// characters first, then the end word whose data byte is don't-care noise
	task automatic send_string(input text_t q);
		foreach (q[i]) send_word(q[i], 1'b0);
		send_word(8'($urandom_range(255)), 1'b1);
	endtask

	function automatic void put_text(ref text_t q, input string s);
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
	endfunction

	task automatic send_text(input string s);
		text_t q;
		put_text(q, s);
		send_string(q);
	endtask

	function automatic void put_blanks(ref text_t q, input int min_n);
		int n;
		n = $urandom_range(min_n + 1, min_n);
		repeat (n) q.push_back(($urandom_range(3) == 0) ? 8'h09 : 8'h20);
	endfunction

	function automatic void put_digit(ref text_t q);
		q.push_back(8'd48 + 8'($urandom_range(9)));
	endfunction

	// optional sign, digits, optional point and fraction, optional exponent
	function automatic void put_number(ref text_t q);
		int   digits;
		logic point;
		if ($urandom_range(3) == 0) q.push_back($urandom_range(1) ? 8'h2d : 8'h2b);
		digits = $urandom_range(3);
		point  = (digits == 0) || ($urandom_range(2) == 0);
		repeat (digits) put_digit(q);
		if (point) begin
			q.push_back(".");
			repeat ($urandom_range(2)) put_digit(q);
		end
		if ($urandom_range(4) == 0) begin
			q.push_back($urandom_range(1) ? 8'h65 : 8'h45);
			if ($urandom_range(1)) q.push_back($urandom_range(1) ? 8'h2d : 8'h2b);
			repeat ($urandom_range(2, 1)) put_digit(q);
		end
	endfunction

	// mostly 2 or 3 numbers, now and then 1 or 4 to hit the count check
	function automatic void put_coord(ref text_t q);
		int n;
		if ($urandom_range(9) == 0) n = $urandom_range(1) ? 4 : 1;
		else n = $urandom_range(3, 2);
		for (int i = 0; i < n; i++) begin
			if (i != 0) put_blanks(q, 1);
			put_number(q);
		end
	endfunction

	function automatic void put_nested(ref text_t q, input int nest);
		int n;
		n = (nest == 0) ? $urandom_range(4, 1) : $urandom_range(3, 1);
		q.push_back("(");
		for (int i = 0; i < n; i++) begin
			if (i != 0) begin
				q.push_back(",");
				put_blanks(q, 0);
			end
			if (nest == 0) put_coord(q);
			else put_nested(q, nest - 1);
		end
		q.push_back(")");
	endfunction

	function automatic void put_keyword(ref text_t q);
		string names [7];
		string w;
		logic [7:0] c;
		names = '{"POINT", "LINESTRING", "POLYGON", "MULTIPOINT",
			"MULTILINESTRING", "MULTIPOLYGON", "TRIANGLE"};
		w = names[$urandom_range(6)];
		for (int i = 0; i < w.len(); i++) begin
			c = w[i];
			if ($urandom_range(4) == 0) c = c ^ 8'h20;
			q.push_back(c);
		end
	endfunction

	// EMPTY in random letter case, sometimes a near miss that stays a plain keyword
	function automatic void put_empty_word(ref text_t q);
		string w;
		logic [7:0] c;
		case ($urandom_range(5))
		0:       w = "EMPT";
		1:       w = "EMPTYY";
		2:       w = "EMPTX";
		default: w = "EMPTY";
		endcase
		for (int i = 0; i < w.len(); i++) begin
			c = w[i];
			if ($urandom_range(1)) c = c ^ 8'h20;
			q.push_back(c);
		end
	endfunction

	function automatic void put_geometry(ref text_t q, input int level);
		int n;
		put_keyword(q);
		if ($urandom_range(4) == 0) begin
			put_blanks(q, 1);
			if ($urandom_range(1)) put_text(q, "Z");
			else put_text(q, "ZM");
		end
		if ($urandom_range(7) == 0) begin
			put_blanks(q, 1);
			put_empty_word(q);
			return;
		end
		put_blanks(q, 0);
		if (level > 0 && $urandom_range(3) == 0) begin
			n = $urandom_range(3, 1);
			q.push_back("(");
			for (int i = 0; i < n; i++) begin
				if (i != 0) begin
					q.push_back(",");
					put_blanks(q, 0);
				end
				put_geometry(q, level - 1);
			end
			q.push_back(")");
		end else put_nested(q, $urandom_range(2));
	endfunction

	// replace, insert or drop one byte; half the junk comes from the token alphabet
	function automatic void mutate(ref text_t q);
		string      pick;
		logic [7:0] junk;
		int         pos;
		pick = " \t(),.+-eE09xZ";
		if ($urandom_range(1)) junk = pick[$urandom_range(pick.len() - 1)];
		else junk = 8'($urandom_range(255));
		pos  = (q.size() == 0) ? 0 : $urandom_range(q.size() - 1);
		case ($urandom_range(2))
		0: if (q.size() != 0) q[pos] = junk;
		1: q.insert(pos, junk);
		default: if (q.size() != 0) q.delete(pos);
		endcase
	endfunction

	initial begin
		text_t q;
		int    kind;
		int    first_word;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed strings: field extremes, every token kind and the corner cases
		send_text("");
		send_text("POINT (1 2)");
		send_text("point empty");
		send_text("Point eMpTy");
		send_text("POINT Z (1.5 -2 +3e10)");
		send_text("LINESTRING(10 20,30 40)");
		send_text("POLYGON ((0 0, 1 0, 1 1, 0 0), (.5 .5, .6 .6, .7 .5))");
		send_text("POINT (. -.)");
		send_text("POINT (1 2 3 4)");
		send_text("POINT (1)");
		send_text("POINT (1 2");
		send_text("POINT (1 2))");
		send_text("POINT (1 2)1e");
		send_text("POINT (1 2a)");
		send_text("POINT, (1 2)");
		send_text("\tPOINT\t(1e+5\t2E-3)\t");
		send_text("EMPTYS (1 2)");
		send_text("POINT empt");
		send_text("(1 2)");
		send_text("POINT (1 2,)");
		send_text("MULTIPOINT ((1 2),(3 4))");
		send_text("GEOMETRYCOLLECTION (POINT (1 2), LINESTRING (3 4, 5 6))");
		send_text("POINT (1.2.3 4)");
		send_text("POINT (1e 2)");

		// stray bytes: zero, 7f and the top-bit patterns
		q.delete();
		put_text(q, "POINT ");
		q.push_back(8'h00);
		put_text(q, "(1 2)");
		send_string(q);
		q = '{8'hff, 8'h80, 8'h7f};
		send_string(q);

		// exactly at the nesting limit, then one bracket past it
		q.delete();
		put_text(q, "A");
		repeat (DEPTH_LIMIT) q.push_back("(");
		put_text(q, "1 2");
		repeat (DEPTH_LIMIT) q.push_back(")");
		send_string(q);
		q.delete();
		put_text(q, "A");
		repeat (DEPTH_LIMIT + 1) q.push_back("(");
		send_string(q);

		// random strings: mostly well formed, some damaged, some pure noise;
		// both sides run without idling through the middle of this stretch
		first_word = words_sent;
		while (words_sent - first_word < 450) begin
			steady_send = (words_sent - first_word >= 100) &&
				(words_sent - first_word < 350);
			q.delete();
			kind = $urandom_range(99);
			if (kind < 88) begin
				if ($urandom_range(5) == 0) put_blanks(q, 1);
				put_geometry(q, 1);
				if ($urandom_range(5) == 0) put_blanks(q, 1);
				if (kind >= 70) repeat ($urandom_range(2, 1)) mutate(q);
			end else begin
				repeat ($urandom_range(12)) mutate(q);
			end
			send_string(q);
		end
		steady_send = 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tlast  <= 1'b0;

		// drain outstanding verdicts, then wait for any stray word
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule : wkt_syntax_validator_tb
